### rtl/rbs_pkg.sv
// shared types and constants of the rgb bilinear sampler
`default_nettype none

package rbs_pkg;

  // operation codes of an input transaction
  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  // configuration register indexes
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // field widths
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 10;
  localparam int ADDR_W       = 19;
  localparam int CHAN_W       = 8;
  localparam int PIXEL_W      = 3 * CHAN_W;
  localparam int SX_W         = 18;
  localparam int SY_W         = 17;
  localparam int OUT_W        = 16;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  // register reset values and result ceiling
  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RST  = 11'd1024;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RST = 10'd512;
  localparam logic [OUT_W-1:0]        OUT_MAX    = 16'd65280;

endpackage

`default_nettype wire

### rtl/rgb_bilinear_sampler.sv
// top level of the rgb bilinear sampler: image store, index pipeline and blend
`default_nettype none

// Bilinear RGB888 sampler over a per-stream image store. A write transaction
// (operation 0) stores one pixel; a sample transaction (operation 1) returns
// one result with the red, green and blue intensities in 8.8 fixed point.
// One transaction is accepted per clock cycle while the output side does not
// stall; a sample goes through the index stages, the store, the blend stage and
// the output register. The rate is set by the store: it is held in two identical
// copies, each with one write port and two registered read ports, so the four
// neighbor reads of a sample happen in the same cycle and a pixel write goes
// to both copies at once. Writes and reads are done at the same pipeline stage
// in transaction order, so a sample sees every pixel written before it. Entries
// never written read as undefined. Stall on the output side backs up stage by
// stage, so bubbles in the pipeline keep absorbing new transactions.
module rgb_bilinear_sampler #(
  parameter int MAX_WIDTH     = 1024,
  parameter int MAX_HEIGHT    = 512,
  parameter int NUM_STREAMS   = 2,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_operation,
  input  wire logic                           in_stream_index,
  input  wire logic [rbs_pkg::ADDR_W-1:0]     in_pixel_address,
  input  wire logic [rbs_pkg::CHAN_W-1:0]     in_write_red,
  input  wire logic [rbs_pkg::CHAN_W-1:0]     in_write_green,
  input  wire logic [rbs_pkg::CHAN_W-1:0]     in_write_blue,
  input  wire logic [rbs_pkg::SX_W-1:0]       in_sample_x,
  input  wire logic [rbs_pkg::SY_W-1:0]       in_sample_y,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [rbs_pkg::OUT_W-1:0]           out_red_out,
  output logic [rbs_pkg::OUT_W-1:0]           out_green_out,
  output logic [rbs_pkg::OUT_W-1:0]           out_blue_out,
  // configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [rbs_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [rbs_pkg::PDATA_W-1:0]    pwdata,
  output logic [rbs_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);
  import rbs_pkg::*;

  localparam int PIX   = MAX_WIDTH * MAX_HEIGHT;
  localparam int DEPTH = NUM_STREAMS * PIX;
  localparam int AW    = $clog2(DEPTH);
  localparam int PIX_W = $clog2(PIX);
  localparam int WD_W  = $clog2(MAX_WIDTH + 1);
  localparam int HT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int XI_W  = SX_W - FRACTION_BITS;
  localparam int YI_W  = SY_W - FRACTION_BITS;
  localparam int RW    = YI_W + WD_W;
  localparam int IX_W  = ((RW > XI_W) ? RW : XI_W) + 2;
  localparam int CW    = (IX_W > PIX_W) ? IX_W : PIX_W;
  localparam int AB_W  = FRACTION_BITS + CHAN_W;
  localparam int S_W   = 2 * FRACTION_BITS + CHAN_W;
  localparam logic [FRACTION_BITS:0] ONE = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;

  // configuration registers
  logic [CFG_WIDTH_W-1:0]  cfg_width_r;
  logic [CFG_HEIGHT_W-1:0] cfg_height_r;
  logic                    cfg_wr;
  reg_idx_t                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= WIDTH_RST;
      cfg_height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:  cfg_width_r  <= pwdata[CFG_WIDTH_W-1:0];
        REG_HEIGHT: cfg_height_r <= pwdata[CFG_HEIGHT_W-1:0];
        default:    cfg_width_r  <= cfg_width_r;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  prdata = PDATA_W'(cfg_width_r);
      REG_HEIGHT: prdata = PDATA_W'(cfg_height_r);
      default:    prdata = '0;
    endcase
  end

  // saturated dimensions and last pixel index, refreshed every cycle
  logic [WD_W-1:0]  w_sat_r, w_sat_nxt;
  logic [HT_W-1:0]  h_sat_r, h_sat_nxt;
  logic [PIX_W-1:0] last_r, last_nxt;

  always_comb begin
    if (cfg_width_r == '0) begin
      w_sat_nxt = WD_W'(1);
    end else if (32'(cfg_width_r) > MAX_WIDTH) begin
      w_sat_nxt = WD_W'(MAX_WIDTH);
    end else begin
      w_sat_nxt = WD_W'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      h_sat_nxt = HT_W'(1);
    end else if (32'(cfg_height_r) > MAX_HEIGHT) begin
      h_sat_nxt = HT_W'(MAX_HEIGHT);
    end else begin
      h_sat_nxt = HT_W'(cfg_height_r);
    end
    last_nxt = PIX_W'(32'(w_sat_r) * 32'(h_sat_r) - 32'd1);
  end

  always_ff @(posedge clk) begin
    w_sat_r <= w_sat_nxt;
    h_sat_r <= h_sat_nxt;
    last_r  <= last_nxt;
  end

  // stage valids and per-stage advance enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;
  logic en1, en2, en3, en4, en5, en6, en_out;
  op_t  s4_op_r;

  assign en_out   = !out_valid_r || out_ready;
  assign en6      = !v6_r || en_out;
  assign en5      = !v5_r || en6;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    v1_r        <= in_valid;
      if (en2)    v2_r        <= v1_r;
      if (en3)    v3_r        <= v2_r;
      if (en4)    v4_r        <= v3_r;
      // write transactions end at the store
      if (en5)    v5_r        <= v4_r && (s4_op_r == OP_SAMPLE);
      if (en6)    v6_r        <= v5_r;
      if (en_out) out_valid_r <= v6_r;
    end
  end

  // stage 1: capture the transaction and split the position
  op_t                      s1_op_r;
  logic                     s1_strm_r;
  logic                     s1_strm_ok_r;
  logic                     s1_wr_r;
  logic [ADDR_W-1:0]        s1_waddr_r;
  logic [PIXEL_W-1:0]       s1_pix_r;
  logic [XI_W-1:0]          s1_xa_r;
  logic [YI_W-1:0]          s1_ya_r;
  logic [FRACTION_BITS-1:0] s1_fx_r;
  logic [FRACTION_BITS-1:0] s1_fy_r;
  logic                     strm_ok;

  assign strm_ok = 32'(in_stream_index) < NUM_STREAMS;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op_r      <= op_t'(in_operation);
      s1_strm_r    <= in_stream_index;
      s1_strm_ok_r <= strm_ok;
      s1_wr_r      <= (op_t'(in_operation) == OP_WRITE) && strm_ok &&
                      (32'(in_pixel_address) < PIX);
      s1_waddr_r   <= in_pixel_address;
      s1_pix_r     <= {in_write_red, in_write_green, in_write_blue};
      s1_xa_r      <= in_sample_x[SX_W-1:FRACTION_BITS];
      s1_ya_r      <= in_sample_y[SY_W-1:FRACTION_BITS];
      s1_fx_r      <= in_sample_x[FRACTION_BITS-1:0];
      s1_fy_r      <= in_sample_y[FRACTION_BITS-1:0];
    end
  end

  // stage 2: row offset and stream base
  op_t                      s2_op_r;
  logic                     s2_wr_r, s2_bad_r;
  logic [ADDR_W-1:0]        s2_waddr_r;
  logic [PIXEL_W-1:0]       s2_pix_r;
  logic [XI_W-1:0]          s2_xa_r;
  logic [FRACTION_BITS-1:0] s2_fx_r, s2_fy_r;
  logic [RW-1:0]            s2_rowa_r;
  logic [AW-1:0]            s2_sbase_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_op_r    <= s1_op_r;
      s2_wr_r    <= s1_wr_r;
      s2_bad_r   <= !s1_strm_ok_r;
      s2_waddr_r <= s1_waddr_r;
      s2_pix_r   <= s1_pix_r;
      s2_xa_r    <= s1_xa_r;
      s2_fx_r    <= s1_fx_r;
      s2_fy_r    <= s1_fy_r;
      s2_rowa_r  <= RW'(s1_ya_r) * RW'(w_sat_r);
      s2_sbase_r <= s1_strm_ok_r ? AW'(s1_strm_r) * AW'(PIX) : '0;
    end
  end

  // stage 3: floor-row and ceil-row indexes of the left column
  op_t                      s3_op_r;
  logic                     s3_wr_r, s3_bad_r;
  logic [ADDR_W-1:0]        s3_waddr_r;
  logic [PIXEL_W-1:0]       s3_pix_r;
  logic [FRACTION_BITS-1:0] s3_fx_r, s3_fy_r;
  logic [AW-1:0]            s3_sbase_r;
  logic [IX_W-1:0]          s3_i00_r, s3_i01_r;
  logic [IX_W-1:0]          i00_nxt;

  assign i00_nxt = IX_W'(s2_rowa_r) + IX_W'(s2_xa_r);

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_op_r    <= s2_op_r;
      s3_wr_r    <= s2_wr_r;
      s3_bad_r   <= s2_bad_r;
      s3_waddr_r <= s2_waddr_r;
      s3_pix_r   <= s2_pix_r;
      s3_fx_r    <= s2_fx_r;
      s3_fy_r    <= s2_fy_r;
      s3_sbase_r <= s2_sbase_r;
      s3_i00_r   <= i00_nxt;
      s3_i01_r   <= i00_nxt + ((|s2_fy_r) ? IX_W'(w_sat_r) : '0);
    end
  end

  // stage 4: right column and clamp of all four indexes
  function automatic logic [PIX_W-1:0] clamp_idx(input logic [IX_W-1:0] idx,
                                                 input logic [PIX_W-1:0] last);
    logic [PIX_W-1:0] res;
    res = (CW'(idx) > CW'(last)) ? last : PIX_W'(idx);
    return res;
  endfunction

  logic                     s4_wr_r, s4_bad_r;
  logic [ADDR_W-1:0]        s4_waddr_r;
  logic [PIXEL_W-1:0]       s4_pix_r;
  logic [FRACTION_BITS-1:0] s4_fx_r, s4_fy_r;
  logic [AW-1:0]            s4_sbase_r;
  logic [PIX_W-1:0]         s4_i00_r, s4_i10_r, s4_i01_r, s4_i11_r;
  logic [IX_W-1:0]          i10_nxt, i11_nxt;

  assign i10_nxt = s3_i00_r + IX_W'(|s3_fx_r);
  assign i11_nxt = s3_i01_r + IX_W'(|s3_fx_r);

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_op_r    <= s3_op_r;
      s4_wr_r    <= s3_wr_r;
      s4_bad_r   <= s3_bad_r;
      s4_waddr_r <= s3_waddr_r;
      s4_pix_r   <= s3_pix_r;
      s4_fx_r    <= s3_fx_r;
      s4_fy_r    <= s3_fy_r;
      s4_sbase_r <= s3_sbase_r;
      s4_i00_r   <= clamp_idx(s3_i00_r, last_r);
      s4_i10_r   <= clamp_idx(i10_nxt, last_r);
      s4_i01_r   <= clamp_idx(s3_i01_r, last_r);
      s4_i11_r   <= clamp_idx(i11_nxt, last_r);
    end
  end

  // image store: two copies, one write and two reads each per cycle while the store stage advances
  logic [PIXEL_W-1:0] mem_a [DEPTH];
  logic [PIXEL_W-1:0] mem_b [DEPTH];
  logic [AW-1:0]      wr_addr, a00, a10, a01, a11;
  logic               mem_we;
  logic [PIXEL_W-1:0] s5_p00_r, s5_p10_r, s5_p01_r, s5_p11_r;

  assign wr_addr = s4_sbase_r + AW'(s4_waddr_r);
  assign a00     = s4_sbase_r + AW'(s4_i00_r);
  assign a10     = s4_sbase_r + AW'(s4_i10_r);
  assign a01     = s4_sbase_r + AW'(s4_i01_r);
  assign a11     = s4_sbase_r + AW'(s4_i11_r);
  assign mem_we  = en5 && v4_r && s4_wr_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem_a[wr_addr] <= s4_pix_r;
    if (en5) begin
      s5_p00_r <= mem_a[a00];
      s5_p10_r <= mem_a[a10];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_b[wr_addr] <= s4_pix_r;
    if (en5) begin
      s5_p01_r <= mem_b[a01];
      s5_p11_r <= mem_b[a11];
    end
  end

  logic                     s5_bad_r;
  logic [FRACTION_BITS-1:0] s5_fx_r, s5_fy_r;

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_bad_r <= s4_bad_r;
      s5_fx_r  <= s4_fx_r;
      s5_fy_r  <= s4_fy_r;
    end
  end

  // stage 6: horizontal blend of both rows, channel 0 is red
  logic [FRACTION_BITS:0]   wx0;
  logic [AB_W-1:0]          a_nxt [3];
  logic [AB_W-1:0]          b_nxt [3];
  logic [AB_W-1:0]          s6_a_r [3];
  logic [AB_W-1:0]          s6_b_r [3];
  logic                     s6_bad_r;
  logic [FRACTION_BITS-1:0] s6_fy_r;

  assign wx0 = ONE - {1'b0, s5_fx_r};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      a_nxt[c] = AB_W'(wx0) * AB_W'(s5_p00_r[(2 - c) * CHAN_W +: CHAN_W]) +
                 AB_W'(s5_fx_r) * AB_W'(s5_p10_r[(2 - c) * CHAN_W +: CHAN_W]);
      b_nxt[c] = AB_W'(wx0) * AB_W'(s5_p01_r[(2 - c) * CHAN_W +: CHAN_W]) +
                 AB_W'(s5_fx_r) * AB_W'(s5_p11_r[(2 - c) * CHAN_W +: CHAN_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_a_r   <= a_nxt;
      s6_b_r   <= b_nxt;
      s6_bad_r <= s5_bad_r;
      s6_fy_r  <= s5_fy_r;
    end
  end

  // output stage: vertical blend, truncate to 8.8, zero for a bad stream
  logic [FRACTION_BITS:0] wy0;
  logic [S_W-1:0]         sum [3];
  logic [OUT_W-1:0]       res_nxt [3];
  logic [OUT_W-1:0]       out_res_r [3];

  assign wy0 = ONE - {1'b0, s6_fy_r};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c]     = S_W'(wy0) * S_W'(s6_a_r[c]) + S_W'(s6_fy_r) * S_W'(s6_b_r[c]);
      res_nxt[c] = s6_bad_r ? '0 : sum[c][S_W-1 -: OUT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) out_res_r <= res_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_res_r[0];
  assign out_green_out = out_res_r[1];
  assign out_blue_out  = out_res_r[2];

  // results stay within the 8.8 intensity range
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r[0] <= OUT_MAX && out_res_r[1] <= OUT_MAX &&
                     out_res_r[2] <= OUT_MAX))
    else $error("result above full intensity");

  // a full pipeline behind a stalled result takes no transaction
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && v4_r && v5_r && v6_r && out_valid_r && !out_ready)
      |-> !in_ready)
    else $error("transaction accepted into a full pipeline");

  // neighbor indexes never pass the last pixel of the image
  a_idx_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (s4_i00_r <= last_r && s4_i10_r <= last_r &&
              s4_i01_r <= last_r && s4_i11_r <= last_r))
    else $error("neighbor index beyond image");

  // a write transaction leaving the store stage makes no result
  a_write_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && en5 && s4_op_r == OP_WRITE) |=> !v5_r)
    else $error("write transaction produced a result");

endmodule

`default_nettype wire
